// File: design/process_table_scheduler_core_assert.svh
// assertion helpers for the process table scheduler
`ifndef PROCESS_TABLE_SCHEDULER_CORE_ASSERT_SVH
`define PROCESS_TABLE_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication on the block clock
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the block clock
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/pts_pkg.sv
package pts_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
   localparam int PID_BITS    = 16;
   localparam int IO_BITS     = 16;
   localparam int PRIO_BITS   = 8;
   localparam int SEG_BITS    = 8;
   localparam int TIME_BITS   = 16;

   typedef enum logic [2:0] {
      CMD_CLEAR     = 3'd0,
      CMD_CREATE    = 3'd1,
      CMD_GET       = 3'd2,
      CMD_FINISH    = 3'd3,
      CMD_SET_STATE = 3'd4,
      CMD_INC_IO    = 3'd5,
      CMD_PICK      = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      PS_READY    = 2'd0,
      PS_RUNNING  = 2'd1,
      PS_BLOCKED  = 2'd2,
      PS_FINISHED = 2'd3
   } pstate_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_FULL        = 2'd1,
      STATUS_NOT_FOUND   = 2'd2,
      STATUS_NONE_READY  = 2'd3
   } status_type;

   typedef struct packed {
      logic [PID_BITS-1:0]  pid;
      pstate_type           state;
      logic [IO_BITS-1:0]   io;
      logic [PRIO_BITS-1:0] prio;
      logic [SEG_BITS-1:0]  segment;
      logic [TIME_BITS-1:0] run_time;
   } entry_type;

endpackage

// File: design/process_table_scheduler_core.sv
// Process table with priority select. One command per item; req_stall stays high while a
// command is in work, and the result is held in an output register until taken, so the
// next item can be accepted while a result still waits. The table lives in one memory
// with a registered read; create, get, finish, set-state, increment-io and pick scan it
// one slot per cycle: the item is accepted, every slot is read in turn, the last read
// returns, and the update step writes back and loads the result once the output is free.
// Clear and the unused command go straight to the update step. Free slots are tracked
// by a valid bit per slot, so reset and clear need no sweep of the memory.
`include "process_table_scheduler_core_assert.svh"

module process_table_scheduler_core (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_command,
   input  logic [pts_pkg::PID_BITS-1:0]  req_target_pid,
   input  logic [1:0]                    req_new_state,
   input  logic [pts_pkg::SEG_BITS-1:0]  req_segment,
   input  logic [pts_pkg::PRIO_BITS-1:0] req_prio,
   input  logic [pts_pkg::TIME_BITS-1:0] req_run_time,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [pts_pkg::PID_BITS-1:0]  rsp_result_pid,
   output logic [1:0]                    rsp_entry_state,
   output logic [pts_pkg::IO_BITS-1:0]   rsp_entry_io,
   output logic [pts_pkg::PRIO_BITS-1:0] rsp_entry_prio,
   output logic [pts_pkg::SEG_BITS-1:0]  rsp_entry_segment,
   output logic [pts_pkg::TIME_BITS-1:0] rsp_entry_time
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } seq_state_type;

   localparam logic [pts_pkg::SLOT_BITS-1:0] LAST_SLOT =
      pts_pkg::SLOT_BITS'(pts_pkg::TABLE_SLOTS - 1);

   // table memory
   pts_pkg::entry_type mem [pts_pkg::TABLE_SLOTS];
   pts_pkg::entry_type rd_data_ff;
   logic                          rd_en;
   logic [pts_pkg::SLOT_BITS-1:0] rd_addr;
   logic                          wr_en;
   logic [pts_pkg::SLOT_BITS-1:0] wr_addr;
   pts_pkg::entry_type            wr_data;

   seq_state_type state_ff, state_in;
   logic [pts_pkg::TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [pts_pkg::PID_BITS-1:0]    pid_counter_ff, pid_counter_in;

   pts_pkg::cmd_type               cmd_ff, cmd_in;
   logic [pts_pkg::PID_BITS-1:0]   target_ff, target_in;
   pts_pkg::pstate_type            new_state_ff, new_state_in;
   logic [pts_pkg::SEG_BITS-1:0]   segment_ff, segment_in;
   logic [pts_pkg::PRIO_BITS-1:0]  prio_ff, prio_in;
   logic [pts_pkg::TIME_BITS-1:0]  time_ff, time_in;

   logic                          issuing_ff, issuing_in;
   logic [pts_pkg::SLOT_BITS-1:0] issue_addr_ff, issue_addr_in;
   logic                          pend_ff, pend_in;
   logic [pts_pkg::SLOT_BITS-1:0] tag_ff, tag_in;

   logic                          found_ff, found_in;
   logic [pts_pkg::SLOT_BITS-1:0] sel_idx_ff, sel_idx_in;
   pts_pkg::entry_type            best_ff, best_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   pts_pkg::status_type     rsp_status_ff, rsp_status_in;
   pts_pkg::entry_type      rsp_entry_ff, rsp_entry_in;

   logic accept;
   logic out_free;
   logic commit;
   logic cand;
   logic take;
   logic slot_valid;
   logic is_lookup;
   pts_pkg::entry_type upd;
   logic report;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == ST_UPDATE) && out_free;
   assign req_stall = (state_ff != ST_IDLE);

   assign is_lookup  = cmd_ff inside {pts_pkg::CMD_GET, pts_pkg::CMD_FINISH,
                                      pts_pkg::CMD_SET_STATE, pts_pkg::CMD_INC_IO};
   assign slot_valid = valid_ff[tag_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // scan candidate for the slot whose data just came back
   always_comb begin
      cand = 1'b0;
      take = 1'b0;
      case (cmd_ff)
         pts_pkg::CMD_CREATE: begin
            cand = !slot_valid || (rd_data_ff.state == pts_pkg::PS_FINISHED);
            take = cand && !found_ff;
         end
         pts_pkg::CMD_PICK: begin
            cand = slot_valid && (rd_data_ff.state == pts_pkg::PS_READY);
            take = cand && (!found_ff || (rd_data_ff.io > best_ff.io) ||
                   ((rd_data_ff.io == best_ff.io) && (rd_data_ff.pid < best_ff.pid)));
         end
         default: begin
            cand = is_lookup && slot_valid && (target_ff != '0) &&
                   (rd_data_ff.pid == target_ff);
            take = cand && !found_ff;
         end
      endcase
   end

   // modified entry and reported fields for the update step
   always_comb begin
      upd           = best_ff;
      report        = 1'b0;
      rsp_status_in = pts_pkg::STATUS_OK;
      wr_en         = 1'b0;
      case (cmd_ff)
         pts_pkg::CMD_CREATE: begin
            upd.pid      = pid_counter_ff;
            upd.state    = pts_pkg::PS_READY;
            upd.io       = '0;
            upd.prio     = prio_ff;
            upd.segment  = segment_ff;
            upd.run_time = time_ff;
            report       = found_ff;
            wr_en        = commit && found_ff;
            if (!found_ff) begin
               rsp_status_in = pts_pkg::STATUS_FULL;
            end
         end
         pts_pkg::CMD_GET, pts_pkg::CMD_FINISH, pts_pkg::CMD_SET_STATE,
         pts_pkg::CMD_INC_IO: begin
            if (cmd_ff == pts_pkg::CMD_FINISH) begin
               upd.state = pts_pkg::PS_FINISHED;
            end else if (cmd_ff == pts_pkg::CMD_SET_STATE) begin
               upd.state = new_state_ff;
            end else if ((cmd_ff == pts_pkg::CMD_INC_IO) && (best_ff.io != '1)) begin
               upd.io = best_ff.io + pts_pkg::IO_BITS'(1);
            end
            report = found_ff;
            wr_en  = commit && found_ff && (cmd_ff != pts_pkg::CMD_GET);
            if (!found_ff) begin
               rsp_status_in = pts_pkg::STATUS_NOT_FOUND;
            end
         end
         pts_pkg::CMD_PICK: begin
            report = found_ff;
            if (!found_ff) begin
               rsp_status_in = pts_pkg::STATUS_NONE_READY;
            end
         end
         default: begin
            report = 1'b0;
         end
      endcase
      rsp_entry_in = report ? upd : '0;
   end

   assign wr_addr = sel_idx_ff;
   assign wr_data = upd;
   assign rd_en   = (state_ff == ST_SCAN) && issuing_ff;
   assign rd_addr = issue_addr_ff;

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      pid_counter_in = pid_counter_ff;
      cmd_in         = cmd_ff;
      target_in      = target_ff;
      new_state_in   = new_state_ff;
      segment_in     = segment_ff;
      prio_in        = prio_ff;
      time_in        = time_ff;
      issuing_in     = issuing_ff;
      issue_addr_in  = issue_addr_ff;
      pend_in        = 1'b0;
      tag_in         = tag_ff;
      found_in       = found_ff;
      sel_idx_in     = sel_idx_ff;
      best_in        = best_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = pts_pkg::cmd_type'(req_command);
               target_in     = req_target_pid;
               new_state_in  = pts_pkg::pstate_type'(req_new_state);
               segment_in    = req_segment;
               prio_in       = req_prio;
               time_in       = req_run_time;
               issuing_in    = 1'b1;
               issue_addr_in = '0;
               found_in      = 1'b0;
               if ((req_command == pts_pkg::CMD_CLEAR) ||
                   (req_command > pts_pkg::CMD_PICK)) begin
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issuing_ff) begin
               pend_in = 1'b1;
               tag_in  = issue_addr_ff;
               if (issue_addr_ff == LAST_SLOT) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_addr_in = issue_addr_ff + pts_pkg::SLOT_BITS'(1);
               end
            end
            if (pend_ff) begin
               if (take) begin
                  found_in   = 1'b1;
                  sel_idx_in = tag_ff;
                  best_in    = rd_data_ff;
               end
               if (tag_ff == LAST_SLOT) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (cmd_ff == pts_pkg::CMD_CLEAR) begin
                  valid_in = '0;
               end
               if ((cmd_ff == pts_pkg::CMD_CREATE) && found_ff) begin
                  valid_in[sel_idx_ff] = 1'b1;
                  // pid zero never matches a lookup, so the counter skips it on wrap
                  if (pid_counter_ff == '1) begin
                     pid_counter_in = pts_pkg::PID_BITS'(1);
                  end else begin
                     pid_counter_in = pid_counter_ff + pts_pkg::PID_BITS'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         pid_counter_ff <= pts_pkg::PID_BITS'(1);
         issuing_ff     <= 1'b0;
         pend_ff        <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         pid_counter_ff <= pid_counter_in;
         issuing_ff     <= issuing_in;
         pend_ff        <= pend_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      target_ff     <= target_in;
      new_state_ff  <= new_state_in;
      segment_ff    <= segment_in;
      prio_ff       <= prio_in;
      time_ff       <= time_in;
      issue_addr_ff <= issue_addr_in;
      tag_ff        <= tag_in;
      sel_idx_ff    <= sel_idx_in;
      best_ff       <= best_in;
      if (commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff  <= rsp_entry_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_pid    = rsp_entry_ff.pid;
   assign rsp_entry_state   = rsp_entry_ff.state;
   assign rsp_entry_io      = rsp_entry_ff.io;
   assign rsp_entry_prio    = rsp_entry_ff.prio;
   assign rsp_entry_segment = rsp_entry_ff.segment;
   assign rsp_entry_time    = rsp_entry_ff.run_time;

   `PTS_ASSERT_NOW(a_pid_counter_nonzero, 1'b1, pid_counter_ff != '0,
      "pid counter reached zero")
   `PTS_ASSERT_NOW(a_write_only_on_commit, wr_en, commit && found_ff,
      "table written outside the update step")
   `PTS_ASSERT_NEXT(a_create_marks_slot,
      commit && (cmd_ff == pts_pkg::CMD_CREATE) && found_ff,
      valid_ff[$past(sel_idx_ff)] && rsp_valid_ff,
      "created slot not marked in use")
   `PTS_ASSERT_NEXT(a_pick_is_ready,
      commit && (cmd_ff == pts_pkg::CMD_PICK) && found_ff,
      (rsp_entry_state == pts_pkg::PS_READY) && (rsp_result_pid != '0),
      "picked entry is not ready")

endmodule

// File: sim/process_table_checker.sv
`timescale 1ns / 100ps

module process_table_checker (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [2:0]                    req_command,
   input  logic [pts_pkg::PID_BITS-1:0]  req_target_pid,
   input  logic [1:0]                    req_new_state,
   input  logic [pts_pkg::SEG_BITS-1:0]  req_segment,
   input  logic [pts_pkg::PRIO_BITS-1:0] req_prio,
   input  logic [pts_pkg::TIME_BITS-1:0] req_run_time,

   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_status,
   input  logic [pts_pkg::PID_BITS-1:0]  rsp_result_pid,
   input  logic [1:0]                    rsp_entry_state,
   input  logic [pts_pkg::IO_BITS-1:0]   rsp_entry_io,
   input  logic [pts_pkg::PRIO_BITS-1:0] rsp_entry_prio,
   input  logic [pts_pkg::SEG_BITS-1:0]  rsp_entry_segment,
   input  logic [pts_pkg::TIME_BITS-1:0] rsp_entry_time,

   output int                            mismatch_count,
   output int                            pending_count
);

   typedef struct packed {
      logic [1:0]                    status;
      logic [pts_pkg::PID_BITS-1:0]  pid;
      logic [1:0]                    state;
      logic [pts_pkg::IO_BITS-1:0]   io;
      logic [pts_pkg::PRIO_BITS-1:0] prio;
      logic [pts_pkg::SEG_BITS-1:0]  segment;
      logic [pts_pkg::TIME_BITS-1:0] run_time;
   } reply_type;

   // shadow copy of the process table
   logic [pts_pkg::PID_BITS-1:0]  tbl_pid   [pts_pkg::TABLE_SLOTS];
   logic [1:0]                    tbl_state [pts_pkg::TABLE_SLOTS];
   logic [pts_pkg::IO_BITS-1:0]   tbl_io    [pts_pkg::TABLE_SLOTS];
   logic [pts_pkg::PRIO_BITS-1:0] tbl_prio  [pts_pkg::TABLE_SLOTS];
   logic [pts_pkg::SEG_BITS-1:0]  tbl_seg   [pts_pkg::TABLE_SLOTS];
   logic [pts_pkg::TIME_BITS-1:0] tbl_time  [pts_pkg::TABLE_SLOTS];
   logic [pts_pkg::PID_BITS-1:0]  pid_next;

   reply_type expected_replies [$];
   reply_type seen;

   function automatic reply_type apply_command(
      input logic [2:0]                    cmd,
      input logic [pts_pkg::PID_BITS-1:0]  target,
      input logic [1:0]                    new_state,
      input logic [pts_pkg::SEG_BITS-1:0]  segment,
      input logic [pts_pkg::PRIO_BITS-1:0] prio,
      input logic [pts_pkg::TIME_BITS-1:0] run_time
   );
      reply_type r;
      int hit;
      r = '0;
      hit = -1;
      case (cmd)
         pts_pkg::CMD_CLEAR: begin
            // pid counter is left alone
            for (int i = 0; i < pts_pkg::TABLE_SLOTS; i++) tbl_pid[i] = '0;
         end
         pts_pkg::CMD_CREATE: begin
            for (int i = 0; i < pts_pkg::TABLE_SLOTS; i++) begin
               if (hit < 0 && (tbl_pid[i] == '0 || tbl_state[i] == pts_pkg::PS_FINISHED))
                  hit = i;
            end
            if (hit < 0) begin
               r.status = pts_pkg::STATUS_FULL;
            end else begin
               tbl_pid[hit]   = pid_next;
               tbl_state[hit] = pts_pkg::PS_READY;
               tbl_io[hit]    = '0;
               tbl_prio[hit]  = prio;
               tbl_seg[hit]   = segment;
               tbl_time[hit]  = run_time;
               pid_next = (pid_next == '1) ? pts_pkg::PID_BITS'(1) :
                          pid_next + pts_pkg::PID_BITS'(1);
            end
         end
         pts_pkg::CMD_GET, pts_pkg::CMD_FINISH, pts_pkg::CMD_SET_STATE,
         pts_pkg::CMD_INC_IO: begin
            // pid zero marks a free slot, so it never matches
            if (target != '0) begin
               for (int i = 0; i < pts_pkg::TABLE_SLOTS; i++) begin
                  if (hit < 0 && tbl_pid[i] == target) hit = i;
               end
            end
            if (hit < 0) begin
               r.status = pts_pkg::STATUS_NOT_FOUND;
            end else if (cmd == pts_pkg::CMD_FINISH) begin
               tbl_state[hit] = pts_pkg::PS_FINISHED;
            end else if (cmd == pts_pkg::CMD_SET_STATE) begin
               tbl_state[hit] = new_state;
            end else if (cmd == pts_pkg::CMD_INC_IO && tbl_io[hit] != '1) begin
               tbl_io[hit] = tbl_io[hit] + pts_pkg::IO_BITS'(1);
            end
         end
         pts_pkg::CMD_PICK: begin
            // most io wins, lowest pid breaks a tie
            for (int i = 0; i < pts_pkg::TABLE_SLOTS; i++) begin
               if (tbl_pid[i] != '0 && tbl_state[i] == pts_pkg::PS_READY &&
                   (hit < 0 || tbl_io[i] > tbl_io[hit] ||
                    (tbl_io[i] == tbl_io[hit] && tbl_pid[i] < tbl_pid[hit]))) hit = i;
            end
            if (hit < 0) r.status = pts_pkg::STATUS_NONE_READY;
         end
         default: ;
      endcase
      if (hit >= 0) begin
         r.pid      = tbl_pid[hit];
         r.state    = tbl_state[hit];
         r.io       = tbl_io[hit];
         r.prio     = tbl_prio[hit];
         r.segment  = tbl_seg[hit];
         r.run_time = tbl_time[hit];
      end
      return r;
   endfunction

   task automatic report_failure(input string what, input reply_type want,
                                 input reply_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] %s", $time, what);
         $display("   expected status %0d pid %0d state %0d io %0d prio %0d seg %0d run %0d",
                  want.status, want.pid, want.state, want.io, want.prio, want.segment,
                  want.run_time);
         $display("   actual   status %0d pid %0d state %0d io %0d prio %0d seg %0d run %0d",
                  got.status, got.pid, got.state, got.io, got.prio, got.segment,
                  got.run_time);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pts_pkg::TABLE_SLOTS; i++) begin
            tbl_pid[i]   = '0;
            tbl_state[i] = pts_pkg::PS_READY;
            tbl_io[i]    = '0;
            tbl_prio[i]  = '0;
            tbl_seg[i]   = '0;
            tbl_time[i]  = '0;
         end
         pid_next = pts_pkg::PID_BITS'(1);
         expected_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{status: rsp_status, pid: rsp_result_pid, state: rsp_entry_state,
                     io: rsp_entry_io, prio: rsp_entry_prio, segment: rsp_entry_segment,
                     run_time: rsp_entry_time};
            if (expected_replies.size() == 0) begin
               report_failure("result with no item outstanding", '0, seen);
            end else begin
               if (seen !== expected_replies[0])
                  report_failure("result mismatch", expected_replies[0], seen);
               void'(expected_replies.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            expected_replies.push_back(apply_command(req_command, req_target_pid,
               req_new_state, req_segment, req_prio, req_run_time));
         end
      end
      pending_count = expected_replies.size();
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam logic [2:0] CMD_UNUSED  = 3'd7;
   localparam int         CYCLE_LIMIT = 1_000_000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;

   logic                          req_valid;
   logic                          req_stall;
   logic [2:0]                    req_command;
   logic [pts_pkg::PID_BITS-1:0]  req_target_pid;
   logic [1:0]                    req_new_state;
   logic [pts_pkg::SEG_BITS-1:0]  req_segment;
   logic [pts_pkg::PRIO_BITS-1:0] req_prio;
   logic [pts_pkg::TIME_BITS-1:0] req_run_time;

   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_status;
   logic [pts_pkg::PID_BITS-1:0]  rsp_result_pid;
   logic [1:0]                    rsp_entry_state;
   logic [pts_pkg::IO_BITS-1:0]   rsp_entry_io;
   logic [pts_pkg::PRIO_BITS-1:0] rsp_entry_prio;
   logic [pts_pkg::SEG_BITS-1:0]  rsp_entry_segment;
   logic [pts_pkg::TIME_BITS-1:0] rsp_entry_time;

   int mismatch_count;
   int pending_count;
   int cycle_count;

   // no idling on either side while set
   bit steady_flow;

   // pids seen in ok results, used as lookup targets
   logic [pts_pkg::PID_BITS-1:0] recent_pids [16];
   logic [3:0]                   recent_wr;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   process_table_scheduler_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_target_pid    (req_target_pid),
      .req_new_state     (req_new_state),
      .req_segment       (req_segment),
      .req_prio          (req_prio),
      .req_run_time      (req_run_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_pid    (rsp_result_pid),
      .rsp_entry_state   (rsp_entry_state),
      .rsp_entry_io      (rsp_entry_io),
      .rsp_entry_prio    (rsp_entry_prio),
      .rsp_entry_segment (rsp_entry_segment),
      .rsp_entry_time    (rsp_entry_time)
   );

   process_table_checker table_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_target_pid    (req_target_pid),
      .req_new_state     (req_new_state),
      .req_segment       (req_segment),
      .req_prio          (req_prio),
      .req_run_time      (req_run_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_pid    (rsp_result_pid),
      .rsp_entry_state   (rsp_entry_state),
      .rsp_entry_io      (rsp_entry_io),
      .rsp_entry_prio    (rsp_entry_prio),
      .rsp_entry_segment (rsp_entry_segment),
      .rsp_entry_time    (rsp_entry_time),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("process_table_scheduler_core regression: fail");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic issue_command(
      input logic [2:0]                    cmd,
      input logic [pts_pkg::PID_BITS-1:0]  target,
      input logic [1:0]                    new_state,
      input logic [pts_pkg::SEG_BITS-1:0]  segment,
      input logic [pts_pkg::PRIO_BITS-1:0] prio,
      input logic [pts_pkg::TIME_BITS-1:0] run_time
   );
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command    <= cmd;
      req_target_pid <= target;
      req_new_state  <= new_state;
      req_segment    <= segment;
      req_prio       <= prio;
      req_run_time   <= run_time;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // result side
   initial begin
      int gap;
      bit taken;
      rsp_stall = 1'b0;
      do @(negedge clock); while (reset !== 1'b0);
      forever begin
         gap = steady_flow ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         taken = 1'b0;
         while (!taken) begin
            @(posedge clock);
            taken = rsp_valid && !rsp_stall;
         end
         if (rsp_status == pts_pkg::STATUS_OK && rsp_result_pid != '0) begin
            recent_pids[recent_wr] = rsp_result_pid;
            recent_wr = recent_wr + 4'd1;
         end
         @(negedge clock);
      end
   end

   initial begin
      int                           cmd_roll;
      int                           pid_roll;
      logic [2:0]                   cmd;
      logic [pts_pkg::PID_BITS-1:0] target;

      req_valid      = 1'b0;
      req_command    = pts_pkg::CMD_CLEAR;
      req_target_pid = '0;
      req_new_state  = pts_pkg::PS_READY;
      req_segment    = '0;
      req_prio       = '0;
      req_run_time   = '0;
      steady_flow    = 1'b0;
      recent_wr      = '0;
      for (int i = 0; i < 16; i++) recent_pids[i] = pts_pkg::PID_BITS'(1);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, ties, state changes, reuse, clear
      issue_command(pts_pkg::CMD_PICK,      '0,    pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_GET,       '0,    pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_CREATE,    '0,    pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_CREATE,    '1,    pts_pkg::PS_FINISHED, '1, '1, '1);
      issue_command(pts_pkg::CMD_GET,       16'd1, pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_GET,       16'd2, pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_PICK,      '0,    pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_INC_IO,    16'd2, pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_PICK,      '0,    pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_SET_STATE, 16'd2, pts_pkg::PS_RUNNING,  '0, '0, '0);
      issue_command(pts_pkg::CMD_PICK,      '0,    pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_SET_STATE, 16'd1, pts_pkg::PS_BLOCKED,  '0, '0, '0);
      issue_command(pts_pkg::CMD_PICK,      '0,    pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_FINISH,    16'd1, pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_GET,       16'd1, pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_CREATE,    '0,    pts_pkg::PS_READY,
                    8'h5a, 8'ha5, 16'h1234);
      issue_command(pts_pkg::CMD_GET,       '1,    pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(CMD_UNUSED,             '1,    pts_pkg::PS_FINISHED, '1, '1, '1);
      issue_command(pts_pkg::CMD_SET_STATE, 16'd3, pts_pkg::PS_FINISHED, '0, '0, '0);
      issue_command(pts_pkg::CMD_SET_STATE, 16'd2, pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_INC_IO,    16'd3, pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_CLEAR,     '0,    pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_GET,       16'd2, pts_pkg::PS_READY,    '0, '0, '0);
      issue_command(pts_pkg::CMD_CREATE,    '0,    pts_pkg::PS_READY,
                    8'h81, 8'h18, 16'h8001);
      issue_command(pts_pkg::CMD_PICK,      '0,    pts_pkg::PS_READY,    '0, '0, '0);

      // random mix, lookups mostly aimed at live pids
      for (int n = 0; n < 1975; n++) begin
         steady_flow = (n % 250) < 30;
         cmd_roll = $urandom_range(0, 199);
         if (cmd_roll < 2)        cmd = pts_pkg::CMD_CLEAR;
         else if (cmd_roll < 4)   cmd = CMD_UNUSED;
         else if (cmd_roll < 56)  cmd = pts_pkg::CMD_CREATE;
         else if (cmd_roll < 80)  cmd = pts_pkg::CMD_GET;
         else if (cmd_roll < 104) cmd = pts_pkg::CMD_FINISH;
         else if (cmd_roll < 128) cmd = pts_pkg::CMD_SET_STATE;
         else if (cmd_roll < 168) cmd = pts_pkg::CMD_INC_IO;
         else                     cmd = pts_pkg::CMD_PICK;
         pid_roll = $urandom_range(0, 19);
         if (pid_roll == 0)     target = '0;
         else if (pid_roll < 4) target = pts_pkg::PID_BITS'($urandom_range(0, 65535));
         else                   target = recent_pids[4'($urandom_range(0, 15))];
         issue_command(cmd, target, 2'($urandom_range(0, 3)),
                       pts_pkg::SEG_BITS'($urandom_range(0, 255)),
                       pts_pkg::PRIO_BITS'($urandom_range(0, 255)),
                       pts_pkg::TIME_BITS'($urandom_range(0, 65535)));
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("process_table_scheduler_core regression: pass");
      else
         $display("process_table_scheduler_core regression: fail");
      $finish;
   end

endmodule
